>>> sv/mqcrp_pkg.sv
// shared types and constants of the mqtt receive parser
package mqcrp_pkg;

	// fixed-header first bytes that the parser acts on
	localparam logic [7:0] T_CONNACK  = 8'h20;
	localparam logic [7:0] T_SUBACK   = 8'h90;
	localparam logic [7:0] T_PINGRESP = 8'hD0;
	localparam logic [7:0] T_PUBLISH  = 8'h30;

	localparam logic [6:0] LEN_MASK     = 7'd127;
	localparam logic [7:0] LEN_CONTINUE = 8'd128;
	localparam logic [1:0] LEN_LAST_IDX = 2'd3;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_LENGTH = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_CONNACK_OK   = 3'd1,
		EV_CONNACK_REF  = 3'd2,
		EV_SUBACK_OK    = 3'd3,
		EV_SUBACK_REF   = 3'd4,
		EV_PING_REPLY   = 3'd5,
		EV_PUBLISH_DONE = 3'd6,
		EV_MALFORMED    = 3'd7
	} ev_t;

	typedef struct packed {
		logic ping;
		logic sub;
		logic session;
	} flags_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       packet_end;
		ev_t        event_res;
		logic [7:0] refuse_code;
		flags_t     flags;
	} res_t;

endpackage

>>> sv/mqcrp_parse.sv
// parser state and the per-byte decode step
module mqcrp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic                resync,
	input  logic [1:0]          subscribe_qos,
	output mqcrp_pkg::res_t     res,
	output logic                has_res
);
	import mqcrp_pkg::*;

	phase_t       phase_q, phase_d;
	logic [7:0]   type_q, type_d;
	logic [27:0]  rc_q, rc_d;
	logic [1:0]   idx_q, idx_d;
	logic [27:0]  off_q, off_d;
	logic [15:0]  tl_q, tl_d;
	flags_t       flags_q, flags_d;

	logic         start_pkt;
	logic [27:0]  len_seg;
	logic [27:0]  rc_new;
	logic [28:0]  off_inc;
	logic         last;
	logic [15:0]  tl_new;
	logic [16:0]  tl_new_p2;
	logic [16:0]  tl_cur_p2;

	assign start_pkt = resync || (phase_q != PH_LENGTH && phase_q != PH_BODY
		&& phase_q != PH_SKIP);

	always_comb begin
		unique case (idx_q)
			2'd0:    len_seg = {21'd0, rx_byte[6:0] & LEN_MASK};
			2'd1:    len_seg = {14'd0, rx_byte[6:0] & LEN_MASK, 7'd0};
			2'd2:    len_seg = {7'd0, rx_byte[6:0] & LEN_MASK, 14'd0};
			default: len_seg = {rx_byte[6:0] & LEN_MASK, 21'd0};
		endcase
	end

	assign rc_new    = rc_q | len_seg;
	assign off_inc   = {1'b0, off_q} + 29'd1;
	assign last      = off_inc >= {1'b0, rc_q};
	assign tl_new    = {tl_q[15:8], rx_byte};
	assign tl_new_p2 = {1'b0, tl_new} + 17'd2;
	assign tl_cur_p2 = {1'b0, tl_q} + 17'd2;

	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		rc_d    = rc_q;
		idx_d   = idx_q;
		off_d   = off_q;
		tl_d    = tl_q;
		flags_d = flags_q;
		res.payload_byte  = 8'd0;
		res.payload_valid = 1'b0;
		res.packet_end    = 1'b0;
		res.event_res     = EV_NONE;
		res.refuse_code   = 8'd0;

		if (start_pkt) begin
			type_d  = rx_byte;
			phase_d = PH_LENGTH;
			idx_d   = 2'd0;
			rc_d    = 28'd0;
			off_d   = 28'd0;
			tl_d    = 16'd0;
		end else if (phase_q == PH_LENGTH) begin
			rc_d = rc_new;
			if (((rx_byte & LEN_CONTINUE) != 8'd0) && idx_q != LEN_LAST_IDX) begin
				idx_d = idx_q + 2'd1;
			end else if (rc_new == 28'd0) begin
				res.packet_end = 1'b1;
				phase_d = PH_HEADER;
				if (type_q == T_PINGRESP) begin
					flags_d.ping  = 1'b1;
					res.event_res = EV_PING_REPLY;
				end else if (type_q == T_CONNACK || type_q == T_SUBACK ||
						type_q == T_PUBLISH) begin
					res.event_res = EV_MALFORMED;
				end
			end else begin
				phase_d = PH_BODY;
				off_d   = 28'd0;
			end
		end else begin
			if (phase_q == PH_BODY) begin
				if (type_q == T_CONNACK) begin
					if (off_q == 28'd1) begin
						if (rx_byte == 8'd0) begin
							flags_d.session = 1'b1;
							res.event_res   = EV_CONNACK_OK;
						end else begin
							flags_d         = '0;
							res.event_res   = EV_CONNACK_REF;
							res.refuse_code = rx_byte;
						end
					end else if (last && off_q == 28'd0) begin
						res.event_res = EV_MALFORMED;
					end
				end else if (type_q == T_SUBACK) begin
					if (off_q == 28'd2) begin
						if (rx_byte == {6'd0, subscribe_qos}) begin
							flags_d.sub   = 1'b1;
							flags_d.ping  = 1'b0;
							res.event_res = EV_SUBACK_OK;
						end else begin
							flags_d       = '0;
							res.event_res = EV_SUBACK_REF;
						end
					end else if (last && off_q < 28'd2) begin
						res.event_res = EV_MALFORMED;
					end
				end else if (type_q == T_PINGRESP) begin
					if (last) begin
						flags_d.ping  = 1'b1;
						res.event_res = EV_PING_REPLY;
					end
				end else if (type_q == T_PUBLISH) begin
					if (off_q == 28'd0) begin
						tl_d = {rx_byte, 8'd0};
						if (last) begin
							res.event_res = EV_MALFORMED;
						end
					end else if (off_q == 28'd1) begin
						tl_d = tl_new;
						if ({11'd0, tl_new_p2} > rc_q) begin
							res.event_res = EV_MALFORMED;
							phase_d       = PH_SKIP;
						end else if (last) begin
							res.event_res = EV_PUBLISH_DONE;
						end
					end else begin
						if (off_q >= {11'd0, tl_cur_p2}) begin
							res.payload_byte  = rx_byte;
							res.payload_valid = 1'b1;
						end
						if (last) begin
							res.event_res = EV_PUBLISH_DONE;
						end
					end
				end
			end
			off_d = off_inc[27:0];
			if (last) begin
				res.packet_end = 1'b1;
				phase_d        = PH_HEADER;
			end
		end
		res.flags = flags_d;
	end

	assign has_res = res.payload_valid || res.packet_end || (res.event_res != EV_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			type_q  <= 8'd0;
			rc_q    <= 28'd0;
			idx_q   <= 2'd0;
			off_q   <= 28'd0;
			tl_q    <= 16'd0;
			flags_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			rc_q    <= rc_d;
			idx_q   <= idx_d;
			off_q   <= off_d;
			tl_q    <= tl_d;
			flags_q <= flags_d;
		end
	end

endmodule

>>> sv/mqcrp_out_reg.sv
// result register on the output channel
module mqcrp_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  mqcrp_pkg::res_t d,
	input  logic            out_ready,
	output logic            out_valid,
	output logic            slot_free,
	output mqcrp_pkg::res_t q
);
	import mqcrp_pkg::*;

	logic  valid_q;
	res_t  res_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign q         = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= d;
		end
	end

endmodule

>>> sv/mqtt_client_receive_parser_core.sv
// top level of the mqtt 3.1.1 receive parser
// Takes one received mqtt byte per item and decodes the fixed header, the
// remaining length (four bytes at most) and the bodies of connack, suback,
// pingresp and qos0 publish; all other packets are skipped to their end.
// A byte that causes a result (payload byte, packet end or event) yields one
// output item, which passes first through the input register and then through
// the result register. Bytes without a result produce no output item.
// Throughput is one byte per cycle; the whole decode step sits between the
// input register and the result register, and the input stalls only while a
// finished result is held by out_ready low. in_ready follows out_ready
// combinationally. subscribe_qos resets to 1 and is written via cfg_we.
module mqtt_client_receive_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       resync,
	// output channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic       packet_end,
	output logic [2:0] event_res,
	output logic [7:0] refuse_code,
	output logic       session_accepted,
	output logic       subscribed,
	output logic       ping_answered
);
	import mqcrp_pkg::*;

	// granted qos that a suback must carry
	logic [1:0] sub_qos_q;

	// input register stage
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       resync_s1;

	logic       step;
	logic       slot_free;
	logic       has_res;
	res_t       res;
	res_t       res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_qos_q <= 2'd1;
		end else if (cfg_we) begin
			sub_qos_q <= cfg_wdata;
		end
	end

	// step the parser whenever an item sits in stage 1 and the result slot can take it
	assign step     = valid_s1 && slot_free;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
			resync_s1  <= resync;
		end
	end

	mqcrp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_byte       (rx_byte_s1),
		.resync        (resync_s1),
		.subscribe_qos (sub_qos_q),
		.res           (res),
		.has_res       (has_res)
	);

	// only bytes that produce something go to the output
	mqcrp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && has_res),
		.d         (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.slot_free (slot_free),
		.q         (res_out)
	);

	assign payload_byte     = res_out.payload_byte;
	assign payload_valid    = res_out.payload_valid;
	assign packet_end       = res_out.packet_end;
	assign event_res        = res_out.event_res;
	assign refuse_code      = res_out.refuse_code;
	assign session_accepted = res_out.flags.session;
	assign subscribed       = res_out.flags.sub;
	assign ping_answered    = res_out.flags.ping;

endmodule

>>> sv/mqcrp_checker.sv
// port-level checks of the mqtt receive parser and their bind
module mqcrp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] payload_byte,
	input logic       payload_valid,
	input logic       packet_end,
	input logic [2:0] event_res,
	input logic [7:0] refuse_code,
	input logic       session_accepted,
	input logic       subscribed,
	input logic       ping_answered
);
	import mqcrp_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(event_res) && $stable(packet_end))
		else $error("output item changed while stalled");

	// payload bytes only carry no event or publish done
	a_payload_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> event_res == EV_NONE
			|| event_res == EV_PUBLISH_DONE)
		else $error("payload byte with foreign event");

	// accepted connack leaves the session flag set
	a_connack_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_CONNACK_OK |-> session_accepted)
		else $error("connack ok without session flag");

	// a refusal clears every flag
	a_refuse_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_CONNACK_REF || event_res == EV_SUBACK_REF)
			|-> !session_accepted && !subscribed && !ping_answered)
		else $error("refusal left a flag set");

	// refuse code only on a refused connack, and it is never zero there
	a_refuse_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (refuse_code != 8'd0) == (event_res == EV_CONNACK_REF))
		else $error("refuse code inconsistent with event");

endmodule

bind mqtt_client_receive_parser_core mqcrp_checker u_mqcrp_checker (.*);
